// File: rtl/core/dfa_pkg.sv
`default_nettype none
package dfa_pkg;

  localparam int ROM_CHARS      = 16384;
  localparam int USER_CHARS     = 192;
  localparam int BYTES_PER_CHAR = 32;

  localparam int ROM_BYTES  = ROM_CHARS * BYTES_PER_CHAR;
  localparam int USER_BYTES = USER_CHARS * BYTES_PER_CHAR;
  localparam int IDX_W      = $clog2(BYTES_PER_CHAR);
  localparam int RAW        = $clog2(ROM_BYTES);
  localparam int UAW        = $clog2(USER_BYTES);
  localparam int UCW        = UAW - IDX_W;

  localparam logic [7:0] CC_OFF     = 8'h01;
  localparam logic [7:0] CC_BASE_LO = 8'h08;
  localparam logic [7:0] CC_BASE_HI = 8'h10;
  localparam logic [7:0] KIND_ROM   = 8'h04;
  localparam logic [7:0] KIND_USER  = 8'h02;

  localparam logic [6:0] USER_FIRST_CODE = 7'h20;
  localparam logic [6:0] USER_END_CODE   = 7'h7F;
  localparam logic [8:0] USER_BANK_CHARS = 9'd96;
  localparam logic [7:0] READ_IDLE_BYTE  = 8'hFF;

  typedef enum logic [1:0] {
    CMD_CTRL_WR  = 2'd0,
    CMD_DATA_WR  = 2'd1,
    CMD_DATA_RD  = 2'd2,
    CMD_ROM_LOAD = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SEL_FF   = 2'd0,
    SEL_ROM  = 2'd1,
    SEL_USER = 2'd2
  } rd_sel_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_RUN   = 2'd1,
    ST_HOLD  = 2'd2
  } state_t;

  typedef struct packed {
    logic           user_we;
    logic [UAW-1:0] user_addr;
    logic           rom_we;
    logic [RAW-1:0] rom_waddr;
    logic [RAW-1:0] rom_raddr;
    logic [7:0]     wdata;
    logic           rd_en;
    rd_sel_t        sel;
  } mem_req_t;

endpackage
`default_nettype wire

// File: rtl/core/dfa_ram.sv
`default_nettype none
module dfa_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/dfa_ctrl.sv
`default_nettype none
module dfa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [1:0]        cmd,
  input  wire logic [7:0]        data,
  input  wire logic [18:0]       rom_address,
  output dfa_pkg::mem_req_t      req
);
  import dfa_pkg::*;

  logic [7:0]       control_code_r, control_code_nxt;
  logic [15:0]      font_kind_r, font_kind_nxt;
  logic             kind_armed_r, kind_armed_nxt;
  logic             access_on_r, access_on_nxt;
  logic [IDX_W-1:0] byte_index_r, byte_index_nxt;
  logic [13:0]      char_base_r, char_base_nxt;

  cmd_t       cmd_c;
  logic [6:0] lo;
  logic [8:0] user_char;
  logic       user_ok;
  logic       rom_ok;
  logic       load_ok;

  assign cmd_c     = cmd_t'(cmd);
  assign lo        = char_base_r[6:0];
  assign user_char = (font_kind_r[2] ? USER_BANK_CHARS : 9'd0) + {2'b00, lo}
                     - {2'b00, USER_FIRST_CODE};
  assign user_ok   = (lo > USER_FIRST_CODE) && (lo < USER_END_CODE)
                     && (user_char < 9'(USER_CHARS));
  assign rom_ok    = {1'b0, char_base_r} < 15'(ROM_CHARS);
  assign load_ok   = {1'b0, rom_address} < 20'(ROM_BYTES);

  always_comb begin
    control_code_nxt = control_code_r;
    font_kind_nxt    = font_kind_r;
    kind_armed_nxt   = kind_armed_r;
    access_on_nxt    = access_on_r;
    byte_index_nxt   = byte_index_r;
    char_base_nxt    = char_base_r;

    req.user_we   = 1'b0;
    req.user_addr = UAW'({user_char[UCW-1:0], byte_index_r});
    req.rom_we    = 1'b0;
    req.rom_waddr = rom_address[RAW-1:0];
    req.rom_raddr = RAW'({char_base_r, byte_index_r});
    req.wdata     = data;
    req.rd_en     = 1'b0;
    req.sel       = SEL_FF;

    if (accept) begin
      unique case (cmd_c)
        CMD_CTRL_WR: begin
          control_code_nxt = data;
          if (data == CC_OFF) begin
            access_on_nxt = 1'b0;
          end
          if (kind_armed_r) begin
            font_kind_nxt  = {data, font_kind_r[7:0]};
            access_on_nxt  = 1'b1;
            byte_index_nxt = '0;
            kind_armed_nxt = 1'b0;
          end
        end
        CMD_DATA_WR: begin
          kind_armed_nxt = 1'b0;
          if (access_on_r) begin
            req.user_we    = user_ok;
            byte_index_nxt = byte_index_r + 1'b1;
          end else begin
            case (control_code_r)
              CC_BASE_HI: char_base_nxt = {data[6:0], char_base_r[6:0]};
              CC_BASE_LO: char_base_nxt = {char_base_r[13:7], data[6:0]};
              CC_OFF: begin
                font_kind_nxt = {font_kind_r[15:8], data};
                if (data[1]) begin
                  kind_armed_nxt = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        CMD_DATA_RD: begin
          req.rd_en = 1'b1;
          if (access_on_r) begin
            if (font_kind_r[15:8] == KIND_ROM) begin
              req.sel        = rom_ok ? SEL_ROM : SEL_FF;
              byte_index_nxt = byte_index_r + 1'b1;
            end else if (font_kind_r[15:8] == KIND_USER) begin
              req.sel        = user_ok ? SEL_USER : SEL_FF;
              byte_index_nxt = byte_index_r + 1'b1;
            end
          end
        end
        CMD_ROM_LOAD: req.rom_we = load_ok;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_code_r <= '0;
      font_kind_r    <= '0;
      kind_armed_r   <= 1'b0;
      access_on_r    <= 1'b0;
      byte_index_r   <= '0;
      char_base_r    <= '0;
    end else begin
      control_code_r <= control_code_nxt;
      font_kind_r    <= font_kind_nxt;
      kind_armed_r   <= kind_armed_nxt;
      access_on_r    <= access_on_nxt;
      byte_index_r   <= byte_index_nxt;
      char_base_r    <= char_base_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/dbcs_font_access_port.sv
// Font access port pair of a double-byte text display adapter. One beat on the input
// channel is one bus access: a control-port write, a data-port write, a data-port read
// or a ROM font byte load. Writes and loads never hold up the next beat. A read is
// registered in the ROM or user font memory, then in the output register, and gives
// one output beat; input is stalled until it enters that register. After reset the
// user font memory is cleared one byte a cycle, all 6144 bytes, while input is stalled.
// The ROM font is not cleared and must be loaded before it is read.
`default_nettype none
module dbcs_font_access_port (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [7:0]  in_data,
  input  wire logic [18:0] in_rom_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_read_data
);
  import dfa_pkg::*;

  state_t         state_r, state_nxt;
  logic [UAW-1:0] clr_cnt_r, clr_cnt_nxt;
  rd_sel_t        sel_r;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_data_r;
  logic           accept;
  logic           clearing;
  logic           out_load;
  logic           clr_last;
  mem_req_t       req;
  logic           uram_we;
  logic [UAW-1:0] uram_waddr;
  logic [7:0]     uram_wdata;
  logic [7:0]     user_q;
  logic [7:0]     rom_q;
  logic [7:0]     result;

  assign accept   = in_valid && !in_stall;
  assign clr_last = clr_cnt_r == UAW'(USER_BYTES - 1);

  dfa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .cmd         (in_cmd),
    .data        (in_data),
    .rom_address (in_rom_address),
    .req         (req)
  );

  assign uram_we    = clearing || req.user_we;
  assign uram_waddr = clearing ? clr_cnt_r : req.user_addr;
  assign uram_wdata = clearing ? 8'h00 : req.wdata;

  dfa_ram #(.DEPTH(USER_BYTES), .AW(UAW), .DW(8)) u_user_ram (
    .clk   (clk),
    .we    (uram_we),
    .waddr (uram_waddr),
    .wdata (uram_wdata),
    .re    (req.rd_en),
    .raddr (req.user_addr),
    .rdata (user_q)
  );

  dfa_ram #(.DEPTH(ROM_BYTES), .AW(RAW), .DW(8)) u_rom_ram (
    .clk   (clk),
    .we    (req.rom_we),
    .waddr (req.rom_waddr),
    .wdata (req.wdata),
    .re    (req.rd_en),
    .raddr (req.rom_raddr),
    .rdata (rom_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_RUN;
      ST_RUN:   if (accept && req.rd_en) state_nxt = ST_HOLD;
      ST_HOLD:  if (!out_valid_r || !out_stall) state_nxt = ST_RUN;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    clearing = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_CLEAR: clearing = 1'b1;
      ST_RUN:   in_stall = 1'b0;
      ST_HOLD:  out_load = !out_valid_r || !out_stall;
      default:  ;
    endcase
  end

  always_comb begin
    case (sel_r)
      SEL_ROM:  result = rom_q;
      SEL_USER: result = user_q;
      default:  result = READ_IDLE_BYTE;
    endcase
  end

  assign clr_cnt_nxt   = clearing ? clr_cnt_r + 1'b1 : clr_cnt_r;
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req.rd_en) begin
      sel_r <= req.sel;
    end
    if (out_load) begin
      out_data_r <= result;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule
`default_nettype wire

// File: rtl/core/dfa_checker.sv
`default_nettype none
module dfa_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [1:0] in_cmd,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_read_data
);
  import dfa_pkg::*;

  logic rd_beat;
  logic other_beat;

  assign rd_beat    = in_valid && !in_stall && (in_cmd == CMD_DATA_RD);
  assign other_beat = in_valid && !in_stall && (in_cmd != CMD_DATA_RD);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data))
    else $error("stalled output beat changed");

  a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    rd_beat |=> in_stall)
    else $error("input taken while a read is in flight");

  a_write_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    other_beat |=> !in_stall)
    else $error("input stalled after a non-read beat");

  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output beat without a pending read");

endmodule

bind dbcs_font_access_port dfa_checker u_dfa_checker (.*);
`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import dfa_pkg::*;

  localparam int LONG_HOLD = 400;
  localparam int ITEM_TARGET = 1400;

  class font_port_predictor;
    logic [7:0]  ctrl_code;
    logic [15:0] kind;
    bit          armed;
    bit          access_on;
    logic [4:0]  idx;
    logic [13:0] base;
    logic [7:0]  user_bytes [USER_BYTES];
    logic [7:0]  rom_bytes [int];
    logic [7:0]  read_bytes_due [$];
    int          mismatches;

    function new();
      ctrl_code  = '0;
      kind       = '0;
      armed      = 0;
      access_on  = 0;
      idx        = '0;
      base       = '0;
      mismatches = 0;
      foreach (user_bytes[i]) user_bytes[i] = '0;
    endfunction

    function bit user_ok();
      return base[6:0] > USER_FIRST_CODE && base[6:0] < USER_END_CODE;
    endfunction

    function int user_slot();
      int ch;
      ch = (kind[2] ? int'(USER_BANK_CHARS) : 0) + int'(base[6:0]) - int'(USER_FIRST_CODE);
      return ch * BYTES_PER_CHAR + int'(idx);
    endfunction

    function int rom_slot();
      return int'(base) * BYTES_PER_CHAR + int'(idx);
    endfunction

    // rom byte that the next read would fetch but that was never loaded
    function int missing_rom_byte();
      if (access_on && kind[15:8] == KIND_ROM && int'(base) < ROM_CHARS &&
          !rom_bytes.exists(rom_slot()))
        return rom_slot();
      return -1;
    endfunction

    function void take_beat(cmd_t c, logic [7:0] d, logic [18:0] a);
      logic [7:0] r;
      case (c)
        CMD_CTRL_WR: begin
          ctrl_code = d;
          if (d == CC_OFF) access_on = 0;
          if (armed) begin
            kind      = {d, kind[7:0]};
            access_on = 1;
            idx       = '0;
            armed     = 0;
          end
        end
        CMD_DATA_WR: begin
          armed = 0;
          if (access_on) begin
            if (user_ok() && user_slot() < USER_BYTES) user_bytes[user_slot()] = d;
            idx = idx + 5'd1;
          end else if (ctrl_code == CC_BASE_HI) begin
            base[13:7] = d[6:0];
          end else if (ctrl_code == CC_BASE_LO) begin
            base[6:0] = d[6:0];
          end else if (ctrl_code == CC_OFF) begin
            kind[7:0] = d;
            if (d[1]) armed = 1;
          end
        end
        CMD_DATA_RD: begin
          r = READ_IDLE_BYTE;
          if (access_on) begin
            if (kind[15:8] == KIND_ROM) begin
              if (int'(base) < ROM_CHARS && rom_slot() < ROM_BYTES)
                r = rom_bytes.exists(rom_slot()) ? rom_bytes[rom_slot()] : 8'h00;
              idx = idx + 5'd1;
            end else if (kind[15:8] == KIND_USER) begin
              if (user_ok() && user_slot() < USER_BYTES) r = user_bytes[user_slot()];
              idx = idx + 5'd1;
            end
          end
          read_bytes_due.push_back(r);
        end
        CMD_ROM_LOAD: begin
          if (int'(a) < ROM_BYTES) rom_bytes[int'(a)] = d;
        end
        default: ;
      endcase
    endfunction

    function void match_read(logic [7:0] got);
      logic [7:0] want;
      if (read_bytes_due.size() == 0) begin
        $error("read_data: unexpected beat, actual %02h", got);
        mismatches++;
        return;
      end
      want = read_bytes_due.pop_front();
      if (got !== want) begin
        $error("read_data: expected %02h, actual %02h", want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = CMD_CTRL_WR;
  logic [7:0]  in_data = '0;
  logic [18:0] in_rom_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_read_data;

  font_port_predictor font_model = new();
  bit dense = 0;
  bit flood_hold = 0;
  int beats_sent = 0;
  logic [13:0] rom_pool [8];

  dbcs_font_access_port u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_data       (in_data),
    .in_rom_address(in_rom_address),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data)
  );

  always #6 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (dense) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic drive_beat(cmd_t c, logic [7:0] d, logic [18:0] a);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= c;
    in_data        <= d;
    in_rom_address <= a;
    do @(posedge clk); while (in_stall);
    font_model.take_beat(c, d, a);
    beats_sent++;
  endtask

  // loads the rom byte a read is about to fetch, if it was never loaded, before issuing it
  task automatic put(cmd_t c, logic [7:0] d, logic [18:0] a = '0);
    int miss;
    if (c == CMD_DATA_RD) begin
      miss = font_model.missing_rom_byte();
      if (miss >= 0) drive_beat(CMD_ROM_LOAD, 8'($urandom), 19'(miss));
    end
    drive_beat(c, d, a);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (font_model.read_bytes_due.size() != 0);
  endtask

  task automatic open_access(logic [7:0] kind_hi, logic [13:0] char_no, logic [7:0] kind_lo);
    put(CMD_CTRL_WR, CC_OFF);
    put(CMD_CTRL_WR, CC_OFF);
    put(CMD_CTRL_WR, CC_BASE_HI);
    put(CMD_DATA_WR, {1'($urandom), char_no[13:7]});
    put(CMD_CTRL_WR, CC_BASE_LO);
    put(CMD_DATA_WR, {1'($urandom), char_no[6:0]});
    put(CMD_CTRL_WR, CC_OFF);
    put(CMD_DATA_WR, kind_lo);
    put(CMD_CTRL_WR, kind_hi);
  endtask

  task automatic access_burst(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 65) put(CMD_DATA_RD, 8'($urandom));
      else if (r < 95) put(CMD_DATA_WR, 8'($urandom));
      else put(cmd_t'($urandom_range(0, 3)), 8'($urandom), 19'($urandom));
    end
  endtask

  task automatic access_sequence();
    int r;
    logic [7:0]  kind_hi;
    logic [7:0]  kind_lo;
    logic [13:0] char_no;
    dense = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 99);
    char_no = 14'($urandom);
    if (r < 40) begin
      kind_hi = KIND_ROM;
      if ($urandom_range(0, 9) < 7) char_no = rom_pool[$urandom_range(0, 7)];
    end else if (r < 80) begin
      kind_hi = KIND_USER;
      r = $urandom_range(0, 9);
      if (r < 7) char_no[6:0] = 7'($urandom_range(8'h21, 8'h7E));
      else if (r == 7) char_no[6:0] = USER_FIRST_CODE;
      else if (r == 8) char_no[6:0] = USER_END_CODE;
    end else begin
      kind_hi = 8'($urandom);
    end
    kind_lo = 8'($urandom);
    if ($urandom_range(0, 9) != 0) kind_lo[1] = 1'b1;
    open_access(kind_hi, char_no, kind_lo);
    access_burst($urandom_range(1, 40));
    if ($urandom_range(0, 1) == 0) put(CMD_CTRL_WR, CC_OFF);
    dense = 0;
  endtask

  task automatic directed_items();
    put(CMD_DATA_RD, 8'h00);
    put(CMD_ROM_LOAD, 8'hFF, 19'h00000);
    put(CMD_ROM_LOAD, 8'h00, 19'h7FFFF);
    put(CMD_CTRL_WR, 8'hFF);
    put(CMD_DATA_WR, 8'h5A);
    put(CMD_CTRL_WR, CC_OFF);
    put(CMD_DATA_WR, 8'hFF);
    put(CMD_CTRL_WR, CC_OFF);
    put(CMD_DATA_RD, 8'h00);
    put(CMD_DATA_WR, 8'h00);
    put(CMD_CTRL_WR, CC_OFF);
    put(CMD_CTRL_WR, CC_BASE_HI);
    put(CMD_DATA_WR, 8'hFF);
    put(CMD_CTRL_WR, CC_BASE_LO);
    put(CMD_DATA_WR, 8'h7F);
    put(CMD_CTRL_WR, CC_OFF);
    put(CMD_DATA_WR, 8'h06);
    put(CMD_CTRL_WR, KIND_ROM);
    put(CMD_DATA_RD, 8'h00);
    put(CMD_CTRL_WR, CC_OFF);
    put(CMD_CTRL_WR, CC_BASE_LO);
    put(CMD_DATA_WR, 8'h21);
    put(CMD_CTRL_WR, CC_OFF);
    put(CMD_DATA_WR, 8'h02);
    put(CMD_CTRL_WR, KIND_USER);
    put(CMD_DATA_WR, 8'hA5);
    put(CMD_DATA_RD, 8'h00);
  endtask

  // result side: random stalls, quiet stretches and one long hold on request
  initial begin
    int mode;
    int len;
    wait (rst_n);
    forever begin
      if (flood_hold) begin
        flood_hold = 0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 19);
        len  = $urandom_range(5, 40);
        if (mode == 19) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(30, 90)) @(posedge clk);
        end else begin
          repeat (len) begin
            if (mode < 7) out_stall <= 1'b0;
            else if (mode < 15) out_stall <= ($urandom_range(0, 3) == 0);
            else out_stall <= 1'($urandom);
            @(posedge clk);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) font_model.match_read(out_read_data);
  end

  initial begin
    bit flooded;
    flooded = 0;
    rom_pool[0] = '0;
    rom_pool[1] = '1;
    for (int i = 2; i < 8; i++) rom_pool[i] = 14'($urandom);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    directed_items();
    drain();
    while (beats_sent < ITEM_TARGET) begin
      if (!flooded && beats_sent > ITEM_TARGET / 2) begin
        flooded = 1;
        drain();
        // wait until the receiver has started its long hold
        flood_hold = 1;
        wait (!flood_hold);
        dense = 1;
        open_access(KIND_USER, 14'h0041, 8'h02);
        access_burst(60);
        dense = 0;
        drain();
      end
      if ($urandom_range(0, 99) < 75) begin
        access_sequence();
      end else begin
        repeat ($urandom_range(1, 8))
          put(cmd_t'($urandom_range(0, 3)), 8'($urandom), 19'($urandom));
      end
      if ($urandom_range(0, 15) == 0) drain();
    end
    drain();
    repeat (20) @(posedge clk);
    if (font_model.mismatches == 0 && font_model.read_bytes_due.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/dfa_pkg.sv
rtl/core/dfa_ram.sv
rtl/core/dfa_ctrl.sv
rtl/core/dbcs_font_access_port.sv
rtl/core/dfa_checker.sv
verif/tb_top.sv
